FILE: src/egbr_pkg.sv
// ----------------------------------------------------------------------------
// egbr_pkg
// Shared types and constants of the Exp-Golomb bit reader: command kinds,
// status codes, controller states and the control and status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package egbr_pkg;

    localparam int BUF_DEPTH = 256;
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = IDX_W + 1;
    localparam int AVAIL_W   = IDX_W + 4;
    localparam int MAX_READ  = 32;

    typedef enum logic [2:0] {
        KIND_PUSH  = 3'd0,
        KIND_READ  = 3'd1,
        KIND_UE    = 3'd2,
        KIND_SE    = 3'd3,
        KIND_ALIGN = 3'd4,
        KIND_SKIP  = 3'd5,
        KIND_NAL   = 3'd6,
        KIND_CLEAR = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_LONG  = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_PUSH,
        OP_READ_BIT,
        OP_SCAN_BIT,
        OP_DROP_HEAD,
        OP_NAL,
        OP_CLEAR,
        OP_FAIL_EMPTY,
        OP_FAIL_LONG,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FETCH,
        S_READ,
        S_SCAN,
        S_SCAN_CHK,
        S_SUFFIX,
        S_NAL,
        S_FINISH
    } state_t;

    typedef struct packed {
        dp_op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  stored_zero;
        logic  head_partial;
        logic  avail_zero;
        logic  cnt_zero;
        logic  cnt_one;
        logic  cnt_gt_avail;
        logic  cnt_is_max;
        logic  cur_bit;
        logic  last_bit;
        logic  out_free;
    } dp_status_t;

endpackage

FILE: src/egbr_cmd_if.sv
// ----------------------------------------------------------------------------
// egbr_cmd_if
// Command channel: one word carries a command kind, a byte and a bit count.
// ----------------------------------------------------------------------------
interface egbr_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [5:0] bit_count;

    modport source (output valid, output kind, output data_byte, output bit_count,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input bit_count,
                    output ready);
endinterface

FILE: src/egbr_res_if.sv
// ----------------------------------------------------------------------------
// egbr_res_if
// Result channel: one word per command with values and a status code.
// ----------------------------------------------------------------------------
interface egbr_res_if;
    logic               valid;
    logic               ready;
    logic        [31:0] unsigned_value;
    logic signed [31:0] signed_value;
    logic        [1:0]  nal_ref;
    logic        [4:0]  nal_type;
    logic        [1:0]  status;

    modport source (output valid, output unsigned_value, output signed_value,
                    output nal_ref, output nal_type, output status, input ready);
    modport sink   (input valid, input unsigned_value, input signed_value,
                    input nal_ref, input nal_type, input status, output ready);
endinterface

FILE: src/egbr_datapath.sv
// ----------------------------------------------------------------------------
// egbr_datapath
// Byte store, committed and working cursors, bit accumulator and the result
// register. Every read command works on the working cursor, which is copied
// back only when the command completes without error.
// ----------------------------------------------------------------------------
module egbr_datapath import egbr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         stat,
    input  logic [2:0]         in_kind,
    input  logic [7:0]         in_data_byte,
    input  logic [5:0]         in_bit_count,
    input  logic               out_ready,
    output logic               out_valid,
    output logic        [31:0] out_unsigned_value,
    output logic signed [31:0] out_signed_value,
    output logic        [1:0]  out_nal_ref,
    output logic        [4:0]  out_nal_type,
    output logic        [1:0]  out_status
);

    logic [7:0] mem [BUF_DEPTH];
    logic [7:0] rd_q_reg;

    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]   stored_reg, stored_next;
    logic [3:0]         bits_reg, bits_next;
    logic [IDX_W-1:0]   w_idx_reg, w_idx_next;
    logic [CNT_W-1:0]   w_stored_reg, w_stored_next;
    logic [3:0]         w_bits_reg, w_bits_next;
    logic [AVAIL_W-1:0] w_avail_reg, w_avail_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [31:0]        acc_reg, acc_next;
    kind_t              kind_reg, kind_next;
    logic [7:0]         data_reg, data_next;
    status_t            st_reg, st_next;

    logic               out_valid_reg, out_valid_next;
    logic [31:0]        uval_reg, uval_next;
    logic [31:0]        sval_reg, sval_next;
    logic [1:0]         nref_reg, nref_next;
    logic [4:0]         ntype_reg, ntype_next;
    status_t            ost_reg, ost_next;

    logic               full;
    logic [AVAIL_W-1:0] avail_start;
    logic [5:0]         count_clamped;
    logic [2:0]         bit_sel;
    logic               cur_bit;
    logic [IDX_W-1:0]   c_idx;
    logic [CNT_W-1:0]   c_stored;
    logic [3:0]         c_bits;
    logic [31:0]        code;
    logic [31:0]        half;
    logic               read_side;

    assign full          = (stored_reg == CNT_W'(BUF_DEPTH));
    assign avail_start   = (stored_reg == '0) ? '0
                         : ({stored_reg, 3'b000} - AVAIL_W'(4'd8 - bits_reg));
    assign count_clamped = (in_bit_count > 6'(MAX_READ)) ? 6'(MAX_READ) : in_bit_count;
    assign bit_sel       = 3'(w_bits_reg - 4'd1);
    assign cur_bit       = rd_q_reg[bit_sel];
    assign code          = acc_reg - 32'd1;
    assign half          = {1'b0, code[31:1]};
    assign read_side     = (kind_reg != KIND_PUSH) && (kind_reg != KIND_CLEAR);

    // Taking one bit either steps within the head byte or moves to the next one.
    always_comb
    begin
        if (w_bits_reg == 4'd1)
        begin
            c_idx    = w_idx_reg + 1'b1;
            c_stored = w_stored_reg - 1'b1;
            c_bits   = 4'd8;
        end
        else
        begin
            c_idx    = w_idx_reg;
            c_stored = w_stored_reg;
            c_bits   = w_bits_reg - 4'd1;
        end
    end

    always_comb
    begin
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        stored_next    = stored_reg;
        bits_next      = bits_reg;
        w_idx_next     = w_idx_reg;
        w_stored_next  = w_stored_reg;
        w_bits_next    = w_bits_reg;
        w_avail_next   = w_avail_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        kind_next      = kind_reg;
        data_next      = data_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        uval_next      = uval_reg;
        sval_next      = sval_reg;
        nref_next      = nref_reg;
        ntype_next     = ntype_reg;
        ost_next       = ost_reg;

        case (cmd.op)
            OP_START:
            begin
                kind_next     = kind_t'(in_kind);
                data_next     = in_data_byte;
                if (kind_t'(in_kind) == KIND_UE || kind_t'(in_kind) == KIND_SE)
                begin
                    cnt_next = 6'd0;
                end
                else
                begin
                    cnt_next = count_clamped;
                end
                acc_next      = '0;
                st_next       = ST_OK;
                w_idx_next    = rd_idx_reg;
                w_stored_next = stored_reg;
                w_bits_next   = bits_reg;
                w_avail_next  = avail_start;
            end
            OP_PUSH:
            begin
                if (full)
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    wr_idx_next = wr_idx_reg + 1'b1;
                    stored_next = stored_reg + 1'b1;
                end
            end
            OP_READ_BIT:
            begin
                acc_next      = {acc_reg[30:0], cur_bit};
                cnt_next      = cnt_reg - 6'd1;
                w_idx_next    = c_idx;
                w_stored_next = c_stored;
                w_bits_next   = c_bits;
                w_avail_next  = w_avail_reg - 1'b1;
            end
            OP_SCAN_BIT:
            begin
                if (cur_bit)
                begin
                    acc_next = 32'd1;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
                w_idx_next    = c_idx;
                w_stored_next = c_stored;
                w_bits_next   = c_bits;
                w_avail_next  = w_avail_reg - 1'b1;
            end
            OP_DROP_HEAD:
            begin
                w_idx_next    = w_idx_reg + 1'b1;
                w_stored_next = w_stored_reg - 1'b1;
                w_bits_next   = 4'd8;
            end
            OP_NAL:
            begin
                acc_next      = {24'd0, rd_q_reg};
                w_idx_next    = w_idx_reg + 1'b1;
                w_stored_next = w_stored_reg - 1'b1;
                w_bits_next   = 4'd8;
            end
            OP_CLEAR:
            begin
                rd_idx_next = '0;
                wr_idx_next = '0;
                stored_next = '0;
                bits_next   = 4'd8;
            end
            OP_FAIL_EMPTY:
            begin
                st_next = ST_EMPTY;
            end
            OP_FAIL_LONG:
            begin
                st_next = ST_LONG;
            end
            OP_FINISH:
            begin
                out_valid_next = 1'b1;
                ost_next       = st_reg;
                uval_next      = '0;
                sval_next      = '0;
                nref_next      = '0;
                ntype_next     = '0;
                if (st_reg == ST_OK)
                begin
                    if (kind_reg == KIND_UE || kind_reg == KIND_SE)
                    begin
                        uval_next = code;
                    end
                    else
                    begin
                        uval_next = acc_reg;
                    end
                    if (kind_reg == KIND_SE)
                    begin
                        sval_next = code[0] ? (half + 32'd1) : (32'd0 - half);
                    end
                    if (kind_reg == KIND_NAL)
                    begin
                        nref_next  = acc_reg[6:5];
                        ntype_next = acc_reg[4:0];
                    end
                    if (read_side)
                    begin
                        rd_idx_next = w_idx_reg;
                        stored_next = w_stored_reg;
                        bits_next   = w_bits_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_PUSH && !full)
        begin
            mem[wr_idx_reg] <= data_reg;
        end
        rd_q_reg <= mem[w_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            stored_reg    <= '0;
            bits_reg      <= 4'd8;
            w_idx_reg     <= '0;
            w_stored_reg  <= '0;
            w_bits_reg    <= 4'd8;
            w_avail_reg   <= '0;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            kind_reg      <= KIND_PUSH;
            st_reg        <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            stored_reg    <= stored_next;
            bits_reg      <= bits_next;
            w_idx_reg     <= w_idx_next;
            w_stored_reg  <= w_stored_next;
            w_bits_reg    <= w_bits_next;
            w_avail_reg   <= w_avail_next;
            cnt_reg       <= cnt_next;
            acc_reg       <= acc_next;
            kind_reg      <= kind_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        uval_reg  <= uval_next;
        sval_reg  <= sval_next;
        nref_reg  <= nref_next;
        ntype_reg <= ntype_next;
        ost_reg   <= ost_next;
    end

    assign stat.kind         = kind_reg;
    assign stat.stored_zero  = (w_stored_reg == '0);
    assign stat.head_partial = (w_bits_reg != 4'd8);
    assign stat.avail_zero   = (w_avail_reg == '0);
    assign stat.cnt_zero     = (cnt_reg == 6'd0);
    assign stat.cnt_one      = (cnt_reg == 6'd1);
    assign stat.cnt_gt_avail = (AVAIL_W'(cnt_reg) > w_avail_reg);
    assign stat.cnt_is_max   = (cnt_reg == 6'(MAX_READ));
    assign stat.cur_bit      = cur_bit;
    assign stat.last_bit     = (w_bits_reg == 4'd1);
    assign stat.out_free     = !out_valid_reg || out_ready;

    assign out_valid          = out_valid_reg;
    assign out_unsigned_value = uval_reg;
    assign out_signed_value   = signed'(sval_reg);
    assign out_nal_ref        = nref_reg;
    assign out_nal_type       = ntype_reg;
    assign out_status         = ost_reg;

    // The buffer never holds more bytes than it has room for.
    a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= CNT_W'(BUF_DEPTH))
        else $error("stored byte count exceeds the buffer depth");

    // An empty buffer always has its cursor on a byte boundary.
    a_empty_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg == '0 |-> bits_reg == 4'd8)
        else $error("empty buffer with a partly read head byte");

    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg != 4'd0 && bits_reg <= 4'd8)
        else $error("bits remaining in the head byte out of range");

    // Head, tail and fill level stay consistent.
    a_index_gap: assert property (@(posedge clk) disable iff (!rst_n)
        IDX_W'(rd_idx_reg + stored_reg[IDX_W-1:0]) == wr_idx_reg)
        else $error("read index, write index and fill level disagree");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_FINISH |=> out_valid_reg)
        else $error("completed command produced no result word");

endmodule

FILE: src/egbr_ctrl.sv
// ----------------------------------------------------------------------------
// egbr_ctrl
// Command sequencer: accepts a command word, steps the datapath through its
// bit and byte operations, and hands the result to the output register.
// ----------------------------------------------------------------------------
module egbr_ctrl import egbr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.kind)
                    KIND_READ:
                    begin
                        if (stat.cnt_gt_avail || stat.cnt_zero)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    KIND_UE, KIND_SE:
                    begin
                        state_next = stat.avail_zero ? S_FINISH : S_SCAN;
                    end
                    KIND_NAL:
                    begin
                        state_next = stat.stored_zero ? S_FINISH : S_NAL;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_FETCH:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                if (stat.cnt_one)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.last_bit)
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_SCAN:
            begin
                state_next = stat.cur_bit ? S_SUFFIX : S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (stat.cnt_is_max || stat.avail_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SUFFIX:
            begin
                if (stat.cnt_gt_avail || stat.cnt_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_NAL:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_START;
                end
            end
            S_DISPATCH:
            begin
                case (stat.kind)
                    KIND_PUSH:
                    begin
                        cmd.op = OP_PUSH;
                    end
                    KIND_READ:
                    begin
                        if (stat.cnt_gt_avail)
                        begin
                            cmd.op = OP_FAIL_EMPTY;
                        end
                    end
                    KIND_UE, KIND_SE:
                    begin
                        if (stat.avail_zero)
                        begin
                            cmd.op = OP_FAIL_EMPTY;
                        end
                    end
                    KIND_ALIGN:
                    begin
                        if (!stat.stored_zero && stat.head_partial)
                        begin
                            cmd.op = OP_DROP_HEAD;
                        end
                    end
                    KIND_SKIP:
                    begin
                        cmd.op = stat.stored_zero ? OP_FAIL_EMPTY : OP_DROP_HEAD;
                    end
                    KIND_NAL:
                    begin
                        if (stat.stored_zero)
                        begin
                            cmd.op = OP_FAIL_EMPTY;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        cmd.op = OP_CLEAR;
                    end
                    default:
                    begin
                        cmd.op = OP_NONE;
                    end
                endcase
            end
            S_READ:
            begin
                cmd.op = OP_READ_BIT;
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN_BIT;
            end
            S_SCAN_CHK:
            begin
                if (stat.cnt_is_max)
                begin
                    cmd.op = OP_FAIL_LONG;
                end
                else if (stat.avail_zero)
                begin
                    cmd.op = OP_FAIL_EMPTY;
                end
            end
            S_SUFFIX:
            begin
                if (stat.cnt_gt_avail)
                begin
                    cmd.op = OP_FAIL_EMPTY;
                end
            end
            S_NAL:
            begin
                cmd.op = OP_NAL;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.op = OP_FINISH;
                end
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/exp_golomb_bit_reader_top.sv
// ----------------------------------------------------------------------------
// exp_golomb_bit_reader_top
// Byte buffer read most significant bit first, with fixed-length reads,
// Exp-Golomb decoding, byte alignment and NAL header extraction.
// ----------------------------------------------------------------------------
// One command word is taken at a time and gives exactly one result word.
// A fixed-length read takes one bit at a time from the registered read port
// of the byte store, with a fetch state at every byte boundary crossed. An
// Exp-Golomb code scans each leading zero in a scan state and a check state,
// then reads the suffix bits in the same way. A failed command leaves the
// buffer untouched and reports its status.
module exp_golomb_bit_reader_top import egbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    egbr_cmd_if.sink    cmd,
    egbr_res_if.source  res
);

    ctrl_cmd_t  dp_cmd;
    dp_status_t dp_stat;

    egbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    egbr_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (dp_cmd),
        .stat               (dp_stat),
        .in_kind            (cmd.kind),
        .in_data_byte       (cmd.data_byte),
        .in_bit_count       (cmd.bit_count),
        .out_ready          (res.ready),
        .out_valid          (res.valid),
        .out_unsigned_value (res.unsigned_value),
        .out_signed_value   (res.signed_value),
        .out_nal_ref        (res.nal_ref),
        .out_nal_type       (res.nal_type),
        .out_status         (res.status)
    );

endmodule
